>>> rtl/hsec_pkg.sv
// Hamming SEC codec package: widths, parity limits, status type and bit-mapping functions.
package hsec_pkg;

  localparam int unsigned WORD_W     = 63;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned M_W        = 3;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned MIN_PARITY = 2;
  localparam int unsigned MAX_PARITY = 6;
  localparam int unsigned RESET_PARITY = 4;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } codec_op_e;

  typedef struct packed {
    logic              corrected;
    logic [POS_W-1:0]  position;
  } hsec_status_t;

  function automatic logic [M_W-1:0] eff_parity(input logic [M_W-1:0] raw);
    logic [M_W-1:0] m;
    m = raw;
    if (raw < M_W'(MIN_PARITY)) begin
      m = M_W'(MIN_PARITY);
    end else if (raw > M_W'(MAX_PARITY)) begin
      m = M_W'(MAX_PARITY);
    end
    return m;
  endfunction

  function automatic logic [WORD_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    logic [WORD_W:0] full;
    full = ((WORD_W+1)'(1) << len) - (WORD_W+1)'(1);
    return full[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] place_data(input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] r;
    int j;
    r = '0;
    j = 0;
    for (int p = 1; p <= WORD_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        r[p-1] = d[j];
        j++;
      end
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] take_data(input logic [WORD_W-1:0] c);
    logic [WORD_W-1:0] r;
    int j;
    r = '0;
    j = 0;
    for (int p = 1; p <= WORD_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        r[j] = c[p-1];
        j++;
      end
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] syndrome(input logic [WORD_W-1:0] c);
    logic [POS_W-1:0] s;
    s = '0;
    for (int p = 1; p <= WORD_W; p++) begin
      if (c[p-1]) begin
        s = s ^ POS_W'(p);
      end
    end
    return s;
  endfunction

endpackage

>>> rtl/hsec_encoder.sv
// Hamming SEC encoder: scatter data bits and fill parity positions.
module hsec_encoder (
  input  logic [hsec_pkg::WORD_W-1:0] data_i,
  input  logic [hsec_pkg::WORD_W-1:0] data_mask_i,
  output logic [hsec_pkg::WORD_W-1:0] code_o
);
  import hsec_pkg::*;

  logic [WORD_W-1:0] placed;
  logic [POS_W-1:0]  synd;

  always_comb begin
    placed = place_data(data_i & data_mask_i);
    synd   = syndrome(placed);
    code_o = placed;
    for (int i = 0; i < POS_W; i++) begin
      code_o[(1 << i) - 1] = synd[i];
    end
  end

endmodule

>>> rtl/hsec_decoder.sv
// Hamming SEC decoder: syndrome, single-bit correction and data extraction.
module hsec_decoder (
  input  logic [hsec_pkg::WORD_W-1:0] code_i,
  input  logic [hsec_pkg::WORD_W-1:0] code_mask_i,
  output logic [hsec_pkg::WORD_W-1:0] data_o,
  output hsec_pkg::hsec_status_t      status_o
);
  import hsec_pkg::*;

  logic [WORD_W-1:0] code;
  logic [WORD_W-1:0] fixed;
  logic [POS_W-1:0]  synd;

  always_comb begin
    code  = code_i & code_mask_i;
    synd  = syndrome(code);
    fixed = code;
    if (synd != '0) begin
      fixed = code ^ (WORD_W'(1) << (synd - POS_W'(1)));
    end
    data_o             = take_data(fixed);
    status_o.corrected = (synd != '0);
    status_o.position  = synd;
  end

endmodule

>>> rtl/hamming_sec_encode_decode.sv
// Hamming SEC encode/decode top level: parity register, input and result registers.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  command  | start, busy (never high)  | kind_i, word_in_i
//  result   | done_o strobe, one cycle  | word_out_o, corrected_o, error_position_o
//  config   | cfg_valid_i, cfg_ready_o  | cfg_data_i (parity bit count)
//
//  One word per cycle; a taken word passes the input register, then the XOR trees
//  into the result register, where its result appears.
//  Reset clears the strobes and sets the parity bit count to four.
//  The receiver cannot stall, so busy stays low and nothing is held back.
module hamming_sec_encode_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind_i,
  input  logic [hsec_pkg::WORD_W-1:0] word_in_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [hsec_pkg::M_W-1:0]    cfg_data_i,
  output logic                        done_o,
  output logic [hsec_pkg::WORD_W-1:0] word_out_o,
  output logic                        corrected_o,
  output logic [hsec_pkg::POS_W-1:0]  error_position_o
);
  import hsec_pkg::*;

  logic [M_W-1:0]    parity_q;
  logic              valid_q;
  logic              kind_q;
  logic [WORD_W-1:0] word_q;
  logic              done_q;
  logic [WORD_W-1:0] out_q;
  logic              corr_q;
  logic [POS_W-1:0]  pos_q;

  logic [M_W-1:0]    m;
  logic [LEN_W-1:0]  n_len;
  logic [LEN_W-1:0]  k_len;
  logic [WORD_W-1:0] n_mask;
  logic [WORD_W-1:0] k_mask;
  logic [WORD_W-1:0] enc_code;
  logic [WORD_W-1:0] dec_data;
  hsec_status_t      dec_status;

  logic [WORD_W-1:0] out_d;
  logic              corr_d;
  logic [POS_W-1:0]  pos_d;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  assign m      = eff_parity(parity_q);
  assign n_len  = (LEN_W'(1) << m) - LEN_W'(1);
  assign k_len  = n_len - LEN_W'(m);
  assign n_mask = low_mask(n_len);
  assign k_mask = low_mask(k_len);

  hsec_encoder u_enc (
    .data_i      (word_q),
    .data_mask_i (k_mask),
    .code_o      (enc_code)
  );

  hsec_decoder u_dec (
    .code_i      (word_q),
    .code_mask_i (n_mask),
    .data_o      (dec_data),
    .status_o    (dec_status)
  );

  always_comb begin
    if (kind_q == OP_DECODE) begin
      out_d  = dec_data;
      corr_d = dec_status.corrected;
      pos_d  = dec_status.position;
    end else begin
      out_d  = enc_code;
      corr_d = 1'b0;
      pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= M_W'(RESET_PARITY);
      valid_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        parity_q <= cfg_data_i;
      end
      valid_q <= start && !busy;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      kind_q <= kind_i;
      word_q <= word_in_i;
    end
    if (valid_q) begin
      out_q  <= out_d;
      corr_q <= corr_d;
      pos_q  <= pos_d;
    end
  end

  assign done_o           = done_q;
  assign word_out_o       = out_q;
  assign corrected_o      = corr_q;
  assign error_position_o = pos_q;

endmodule

>>> rtl/hsec_checker.sv
// Hamming SEC port checker and its bind to the top level.
module hsec_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        kind_i,
  input logic                        done_o,
  input logic                        corrected_o,
  input logic [hsec_pkg::POS_W-1:0]  error_position_o
);
  import hsec_pkg::*;

  a_word_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted word produced no result");

  a_result_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without an accepted word");

  a_corr_matches_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (corrected_o == (error_position_o != '0)))
    else $error("correction flag disagrees with error position");

  a_encode_no_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(kind_i, 2) == OP_ENCODE)) |-> !corrected_o)
    else $error("encode reported a correction");

endmodule

bind hamming_sec_encode_decode hsec_checker u_hsec_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .kind_i           (kind_i),
  .done_o           (done_o),
  .corrected_o      (corrected_o),
  .error_position_o (error_position_o)
);
